// ===== design/sliding_median_threshold_alarm_core_macros.svh =====
// Assertion macros for the sliding median threshold alarm core.
// Used by the top level; expects aclk and aresetn in the including scope.
`ifndef SLIDING_MEDIAN_THRESHOLD_ALARM_CORE_MACROS_SVH
`define SLIDING_MEDIAN_THRESHOLD_ALARM_CORE_MACROS_SVH

// Holds at every clock edge out of reset.
`define SMTA_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define SMTA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/smta_pkg.sv =====
// Shared constants and types for the sliding median threshold alarm core.
// No dependencies; imported by every module of the block.
package smta_pkg;

    localparam int SMTA_DEF_MAX_WINDOW  = 256;
    localparam int SMTA_DEF_SAMPLE_BITS = 16;
    localparam int SMTA_CFG_W           = 9;
    localparam int SMTA_TOTAL_W         = 32;
    localparam int SMTA_GRP             = 16;

    localparam logic [SMTA_CFG_W-1:0] SMTA_WLEN_RESET = 9'd10;

    // Broadcast control for the sorted cell row.
    typedef struct packed {
        logic upd;   // apply an insert this cycle
        logic rem;   // window full: drop the outgoing value first
    } smta_cell_ctrl_t;

endpackage

// ===== design/sliding_median_threshold_alarm_core.sv =====
// Sliding-window median threshold alarm. Each request on the s_ side carries
// one unsigned sample. The block keeps the last W sample values (W = cfg_wdata,
// 0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW) in a row of sorted
// cells plus an arrival-order delay line. The first W requests after reset or
// after any cfg write only fill the window and return window_ready = 0,
// alarm = 0, doubled_median = 0. After that each sample is compared with
// twice the median of the window (sum of the two middle values for even W,
// double the middle for odd W); sample >= that value sets alarm and bumps a
// wrapping 32-bit alarm total. The oldest sample then leaves and the new one
// is inserted in sorted order. A cfg write keeps the alarm total.
// Samples are taken one at a time: accept, a wait for the second stage of
// the registered median select tree, then the update cycle in which every
// cell shifts at once. The result sits in an output register; a new sample
// is taken while it waits, and the update cycle holds only when the register
// is still full and m_tready is low. No clearing pass after reset.
// Depends on smta_pkg, smta_cell, smta_median_tree, smta_delay_line and the
// assertion macro header.
`include "sliding_median_threshold_alarm_core_macros.svh"

module sliding_median_threshold_alarm_core #(
    parameter int MAX_WINDOW  = smta_pkg::SMTA_DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = smta_pkg::SMTA_DEF_SAMPLE_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // config: window length
    input  logic                                   cfg_wen,
    input  logic [smta_pkg::SMTA_CFG_W-1:0]        cfg_wdata,
    // input request
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // sample, zero pad
    // result request
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((SAMPLE_BITS+41)/8)*8-1:0]      m_tdata,   // alarm, doubled_median,
                                                              // alarm_total, zero pad
    output logic                                   m_tuser    // window_ready
);
    import smta_pkg::*;

    localparam int IDX_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W    = (CNT_W > SMTA_CFG_W) ? CNT_W : SMTA_CFG_W;
    localparam int DMED_W   = SAMPLE_BITS + 1;
    localparam int M_DATA_W = ((SAMPLE_BITS + 41) / 8) * 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [SMTA_CFG_W-1:0]   wlen_reg, wlen_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [IDX_W-1:0]        ptr_reg, ptr_next;
    logic [SMTA_TOTAL_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0]        lo_idx_reg, lo_idx_next, hi_idx_reg, hi_idx_next;
    logic                    mv_reg, mv_next;
    logic                    muser_reg, muser_next;
    logic [M_DATA_W-1:0]     mdata_reg, mdata_next;
    logic [SAMPLE_BITS-1:0]  smp_reg;

    logic [CMP_W-1:0]        wl_x;
    logic [CNT_W-1:0]        w_eff, half_w, cnt_u, ptr_inc;
    logic [IDX_W-1:0]        ptr_eff, ptr_wrap, wr_addr;
    logic                    full, accept, exec_go, alarm;
    logic [SAMPLE_BITS-1:0]  old_val, lo_val, hi_val;
    logic [DMED_W-1:0]       dmed, dmed_out;
    logic [SMTA_TOTAL_W-1:0] cnt_new;
    smta_cell_ctrl_t         cell_ctrl;
    logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] cell_vals;

    // Clamp the window length into 1..MAX_WINDOW.
    assign wl_x = CMP_W'(wlen_reg);
    always_comb begin
        if (wl_x == '0) begin
            w_eff = CNT_W'(1);
        end else if (wl_x > CMP_W'(MAX_WINDOW)) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(wl_x);
        end
    end

    assign full    = fill_reg >= w_eff;
    assign accept  = s_tvalid && s_tready;
    assign exec_go = (state_reg == ST_EXEC) && (!mv_reg || m_tready);

    // Middle slot indexes, registered ahead of the select tree.
    assign half_w = w_eff >> 1;
    always_comb begin
        hi_idx_next = IDX_W'(half_w);
        if (w_eff[0]) begin
            lo_idx_next = IDX_W'(half_w);
        end else begin
            lo_idx_next = IDX_W'(half_w - CNT_W'(1));
        end
    end

    // Oldest slot of the delay line and its successor.
    assign ptr_eff  = (CNT_W'(ptr_reg) >= w_eff) ? '0 : ptr_reg;
    assign ptr_inc  = CNT_W'(ptr_eff) + CNT_W'(1);
    assign ptr_wrap = (ptr_inc >= w_eff) ? '0 : IDX_W'(ptr_inc);
    assign wr_addr  = full ? ptr_eff : fill_reg[IDX_W-1:0];

    // Threshold compare.
    assign dmed     = DMED_W'(lo_val) + DMED_W'(hi_val);
    assign alarm    = full && (DMED_W'(smp_reg) >= dmed);
    assign dmed_out = full ? dmed : '0;
    assign cnt_new  = alarm ? cnt_reg + SMTA_TOTAL_W'(1) : cnt_reg;

    // Cell row: after removal the window holds w-1 entries, while filling it
    // holds fill_reg.
    assign cnt_u         = full ? w_eff - CNT_W'(1) : fill_reg;
    assign cell_ctrl.upd = exec_go;
    assign cell_ctrl.rem = full;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_WAIT;
            end
            ST_WAIT: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_go) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        wlen_next  = wlen_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg;
        muser_next = muser_reg;
        mdata_next = mdata_reg;
        if (exec_go) begin
            cnt_next   = cnt_new;
            if (full) begin
                ptr_next = ptr_wrap;
            end else begin
                fill_next = fill_reg + CNT_W'(1);
            end
            mv_next    = 1'b1;
            muser_next = full;
            mdata_next = M_DATA_W'({cnt_new, dmed_out, alarm});
        end else if (m_tready) begin
            mv_next = 1'b0;
        end
        // A window-length write empties the window.
        if (cfg_wen) begin
            wlen_next = cfg_wdata;
            fill_next = '0;
            ptr_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wlen_reg  <= SMTA_WLEN_RESET;
            fill_reg  <= '0;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            wlen_reg  <= wlen_next;
            fill_reg  <= fill_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            smp_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        lo_idx_reg <= lo_idx_next;
        hi_idx_reg <= hi_idx_next;
        muser_reg  <= muser_next;
        mdata_reg  <= mdata_next;
    end

    smta_delay_line #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_BITS),
        .AW    (IDX_W)
    ) u_delay_line (
        .aclk    (aclk),
        .wr_en   (exec_go),
        .wr_addr (wr_addr),
        .wr_data (smp_reg),
        .rd_addr (ptr_eff),
        .rd_data (old_val)
    );

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        logic [SAMPLE_BITS-1:0] nb_lo, nb_hi;
        if (i == 0) begin : g_first
            assign nb_lo = '0;
        end else begin : g_mid_lo
            assign nb_lo = cell_vals[i-1];
        end
        if (i == MAX_WINDOW - 1) begin : g_last
            assign nb_hi = '0;
        end else begin : g_mid_hi
            assign nb_hi = cell_vals[i+1];
        end
        smta_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .CNT_W       (CNT_W),
            .IDX         (i)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (cell_ctrl),
            .cnt_u   (cnt_u),
            .old_val (old_val),
            .smp     (smp_reg),
            .v_lo    (nb_lo),
            .v_hi    (nb_hi),
            .v_out   (cell_vals[i])
        );
    end

    smta_median_tree #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_median_tree (
        .aclk   (aclk),
        .vals   (cell_vals),
        .lo_idx (lo_idx_reg),
        .hi_idx (hi_idx_reg),
        .lo_val (lo_val),
        .hi_val (hi_val)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    `SMTA_CHECK(a_fill_bound, fill_reg <= w_eff, "fill level beyond window length")
    `SMTA_CHECK(a_ptr_bound, CNT_W'(ptr_reg) < w_eff, "oldest pointer outside window")
    `SMTA_CHECK_NEXT(a_cnt, exec_go && alarm, cnt_reg == $past(cnt_reg) + 32'd1, "no count")
    `SMTA_CHECK(a_alarm_full, !(mv_reg && mdata_reg[0]) || muser_reg, "alarm while window not full")

endmodule

// ===== design/smta_cell.sv =====
// One slot of the sorted window: delete-shift and insert-shift in the same cycle.
// Depends on smta_pkg; sees only its two neighbors and broadcast control and data.
module smta_cell #(
    parameter int SAMPLE_BITS = smta_pkg::SMTA_DEF_SAMPLE_BITS,
    parameter int CNT_W       = 9,
    parameter int IDX         = 0
) (
    input  logic                        aclk,
    input  smta_pkg::smta_cell_ctrl_t   ctrl,
    input  logic [CNT_W-1:0]            cnt_u,     // occupied count after removal
    input  logic [SAMPLE_BITS-1:0]      old_val,
    input  logic [SAMPLE_BITS-1:0]      smp,
    input  logic [SAMPLE_BITS-1:0]      v_lo,      // neighbor below
    input  logic [SAMPLE_BITS-1:0]      v_hi,      // neighbor above
    output logic [SAMPLE_BITS-1:0]      v_out
);
    import smta_pkg::*;

    localparam bit HAS_LO = (IDX > 0);
    localparam logic [CNT_W-1:0] IDX_C    = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_M1_C = CNT_W'(HAS_LO ? IDX - 1 : 0);

    logic [SAMPLE_BITS-1:0] val_reg, val_next;
    logic                   occ_self, occ_lo, shift_self, shift_lo;
    logic [SAMPLE_BITS-1:0] u_self, u_lo;

    // Removal: every occupied slot at or above the first copy of old_val
    // takes its upper neighbor.
    assign occ_self   = IDX_C < cnt_u;
    assign occ_lo     = HAS_LO && (IDX_M1_C < cnt_u);
    assign shift_self = ctrl.rem && occ_self && (val_reg >= old_val);
    assign shift_lo   = ctrl.rem && occ_lo && (v_lo >= old_val);
    assign u_self     = shift_self ? v_hi : val_reg;
    assign u_lo       = shift_lo ? val_reg : v_lo;

    // Insert: slots whose value exceeds the sample move up one.
    always_comb begin
        if (!ctrl.upd || (IDX_C > cnt_u)) begin
            val_next = val_reg;
        end else if (occ_self && (u_self <= smp)) begin
            val_next = u_self;
        end else if (!HAS_LO || (u_lo <= smp)) begin
            val_next = smp;
        end else begin
            val_next = u_lo;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign v_out = val_reg;

endmodule

// ===== design/smta_median_tree.sv =====
// Two-stage registered select tree that picks the two middle slots.
// Depends on smta_pkg for the group size.
module smta_median_tree #(
    parameter int MAX_WINDOW  = smta_pkg::SMTA_DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = smta_pkg::SMTA_DEF_SAMPLE_BITS,
    parameter int IDX_W       = 8
) (
    input  logic                                    aclk,
    input  logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0]  vals,
    input  logic [IDX_W-1:0]                        lo_idx,
    input  logic [IDX_W-1:0]                        hi_idx,
    output logic [SAMPLE_BITS-1:0]                  lo_val,
    output logic [SAMPLE_BITS-1:0]                  hi_val
);
    import smta_pkg::*;

    localparam int NGRP = (MAX_WINDOW + SMTA_GRP - 1) / SMTA_GRP;

    logic [NGRP-1:0][SAMPLE_BITS-1:0] lo_grp_reg, lo_grp_next;
    logic [NGRP-1:0][SAMPLE_BITS-1:0] hi_grp_reg, hi_grp_next;
    logic [SAMPLE_BITS-1:0]           lo_reg, lo_next, hi_reg, hi_next;

    // Stage 1: masked OR inside each group of slots.
    always_comb begin
        int idx;
        for (int g = 0; g < NGRP; g++) begin
            lo_grp_next[g] = '0;
            hi_grp_next[g] = '0;
            for (int k = 0; k < SMTA_GRP; k++) begin
                idx = g * SMTA_GRP + k;
                if (idx < MAX_WINDOW) begin
                    if (IDX_W'(idx) == lo_idx) lo_grp_next[g] = lo_grp_next[g] | vals[idx];
                    if (IDX_W'(idx) == hi_idx) hi_grp_next[g] = hi_grp_next[g] | vals[idx];
                end
            end
        end
    end

    // Stage 2: OR across groups.
    always_comb begin
        lo_next = '0;
        hi_next = '0;
        for (int g = 0; g < NGRP; g++) begin
            lo_next = lo_next | lo_grp_reg[g];
            hi_next = hi_next | hi_grp_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        lo_grp_reg <= lo_grp_next;
        hi_grp_reg <= hi_grp_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
    end

    assign lo_val = lo_reg;
    assign hi_val = hi_reg;

endmodule

// ===== design/smta_delay_line.sv =====
// Arrival-order delay line: one write port, one registered read port.
// Depends on smta_pkg for defaults only.
module smta_delay_line #(
    parameter int DEPTH = smta_pkg::SMTA_DEF_MAX_WINDOW,
    parameter int WIDTH = smta_pkg::SMTA_DEF_SAMPLE_BITS,
    parameter int AW    = 8
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    import smta_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== verif/smta_result_checker.sv =====
// Result checker for the sliding median threshold alarm core: watches the
// config port and both stream channels, predicts each result and compares.
// Depends on smta_pkg for widths and the window length reset value.
`timescale 1ns / 100ps

module smta_result_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [smta_pkg::SMTA_CFG_W-1:0]   cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // sample
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [55:0]                       m_tdata,   // alarm, doubled_median,
                                                         // alarm_total, zero pad
    input  logic                              m_tuser,   // window_ready
    output int                                fail_count,
    output int                                pending,
    output int                                results_checked,
    output int                                alarms_seen
);
    import smta_pkg::*;

    localparam int WMAX = SMTA_DEF_MAX_WINDOW;

    typedef struct packed {
        logic                    window_ready;
        logic                    alarm;
        logic [16:0]             doubled_median;
        logic [SMTA_TOTAL_W-1:0] alarm_total;
    } median_result_t;

    logic [15:0]             arrival_line [WMAX];
    logic [15:0]             sorted_window [WMAX];
    logic [SMTA_CFG_W-1:0]   window_length;
    int                      fill_level;
    int                      oldest_slot;
    logic [SMTA_TOTAL_W-1:0] alarm_count;
    median_result_t          expected_results [$];

    // Sorted insert into the first count entries.
    function automatic void place_sorted(int count, logic [15:0] v);
        int pos;
        pos = count;
        while (pos > 0 && sorted_window[pos-1] > v) begin
            sorted_window[pos] = sorted_window[pos-1];
            pos--;
        end
        sorted_window[pos] = v;
    endfunction

    function automatic median_result_t predict_alarm(logic [15:0] s);
        median_result_t r;
        int w, h, pos, k;
        logic [15:0] old;
        r = '0;
        w = (window_length == 0) ? 1 : ((window_length > WMAX) ? WMAX : int'(window_length));
        if (fill_level < w) begin
            arrival_line[fill_level] = s;
            place_sorted(fill_level, s);
            fill_level++;
        end else begin
            h = w / 2;
            if (w % 2 == 0)
                r.doubled_median = {1'b0, sorted_window[h-1]} + {1'b0, sorted_window[h]};
            else
                r.doubled_median = {sorted_window[h], 1'b0};
            r.window_ready = 1'b1;
            if ({1'b0, s} >= r.doubled_median) begin
                r.alarm = 1'b1;
                alarm_count = alarm_count + 1;
            end
            if (oldest_slot >= w) oldest_slot = 0;
            old = arrival_line[oldest_slot];
            arrival_line[oldest_slot] = s;
            oldest_slot = (oldest_slot + 1 >= w) ? 0 : oldest_slot + 1;
            // drop the first copy of the outgoing value, then slot the new one in
            pos = 0;
            while (pos < w - 1 && sorted_window[pos] != old) pos++;
            for (k = pos; k + 1 < w; k++) sorted_window[k] = sorted_window[k+1];
            place_sorted(w - 1, s);
        end
        r.alarm_total = alarm_count;
        return r;
    endfunction

    always @(posedge aclk) begin
        median_result_t exp_r;
        median_result_t got_r;
        if (!aresetn) begin
            window_length = SMTA_WLEN_RESET;
            fill_level = 0;
            oldest_slot = 0;
            alarm_count = '0;
            expected_results.delete();
            fail_count = 0;
            results_checked = 0;
            alarms_seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_r.window_ready = m_tuser;
                got_r.alarm = m_tdata[0];
                got_r.doubled_median = m_tdata[17:1];
                got_r.alarm_total = m_tdata[49:18];
                if (expected_results.size() == 0) begin
                    $error("result accepted with no sample outstanding");
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    results_checked++;
                    if (got_r.alarm === 1'b1) alarms_seen++;
                    if (got_r.window_ready !== exp_r.window_ready) begin
                        $error("window_ready: expected %0d, actual %0d",
                               exp_r.window_ready, got_r.window_ready);
                        fail_count++;
                    end
                    if (got_r.alarm !== exp_r.alarm) begin
                        $error("alarm: expected %0d, actual %0d", exp_r.alarm, got_r.alarm);
                        fail_count++;
                    end
                    if (got_r.doubled_median !== exp_r.doubled_median) begin
                        $error("doubled_median: expected %0d, actual %0d",
                               exp_r.doubled_median, got_r.doubled_median);
                        fail_count++;
                    end
                    if (got_r.alarm_total !== exp_r.alarm_total) begin
                        $error("alarm_total: expected %0d, actual %0d",
                               exp_r.alarm_total, got_r.alarm_total);
                        fail_count++;
                    end
                end
            end
            if (cfg_wen) begin
                window_length = cfg_wdata;
                fill_level = 0;
                oldest_slot = 0;
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_alarm(s_tdata));
        end
        pending = expected_results.size();
    end

endmodule

// ===== verif/tb_sliding_median_threshold_alarm_core.sv =====
// Testbench top for the sliding median threshold alarm core: clock, reset,
// sample stimulus, window length writes, receiver back-pressure and verdict.
// Depends on smta_pkg, the core and smta_result_checker.
`timescale 1ns / 100ps

module tb_sliding_median_threshold_alarm_core;
    import smta_pkg::*;

    // No request on either channel for this many cycles means the run hung.
    localparam int STALL_LIMIT = 3000;
    // Length of the forced receiver hold-off, long enough to back up the core.
    localparam int HOLD_CYCLES = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wen;
    logic [SMTA_CFG_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;     // sample
    logic                  m_tvalid;
    logic                  m_tready;
    logic [55:0]           m_tdata;     // alarm, doubled_median, alarm_total, zero pad
    logic                  m_tuser;     // window_ready

    int fail_count;
    int pending;
    int results_checked;
    int alarms_seen;

    // Traffic shape, percent of cycles in which each side idles.
    int s_idle_pct;
    int m_stall_pct;
    int hold_seq;
    int sent_count;
    int settings_used;
    int idle_cycles = 0;

    sliding_median_threshold_alarm_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    smta_result_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .alarms_seen     (alarms_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stalls, plus a long hold-off whenever hold_seq moves.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
            end
        end
    end

    // Hang detector: counts cycles with no request moving on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly a quiet baseline so the median stays low and spikes can trip
    // the alarm; a few near-duplicates and full-range values mixed in.
    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 16'($urandom_range(100, 400));
        if (r < 75) return 16'($urandom_range(0, 7));
        if (r < 90) return 16'($urandom_range(800, 65535));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Offers one sample, with random idle cycles in front, and returns at
    // the edge where the core takes it.
    task automatic offer_sample(input logic [15:0] value);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // Window length is only written with the core drained: every result
    // back, then a wait for the pipeline to settle.
    task automatic write_window_length(input logic [SMTA_CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        settings_used++;
    endtask

    task automatic run_burst(input logic [SMTA_CFG_W-1:0] wlen, input int count,
                             input int s_idle, input int m_stall, input bit hold);
        write_window_length(wlen);
        s_idle_pct  = s_idle;
        m_stall_pct = m_stall;
        if (hold) hold_seq <= hold_seq + 1;
        repeat (count) offer_sample(pick_sample());
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wen     <= 1'b0;
        cfg_wdata   <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        hold_seq    <= 0;
        s_idle_pct   = 0;
        m_stall_pct  = 0;
        sent_count   = 0;
        settings_used = 1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset window of 10: fill with both extremes and a run of fives,
        // so twice the median is 10. Then hit it exactly, just miss it, and
        // push the extremes through the full window.
        offer_sample(16'd0);
        offer_sample(16'd65535);
        repeat (8) offer_sample(16'd5);
        offer_sample(16'd10);
        offer_sample(16'd9);
        offer_sample(16'd65535);
        offer_sample(16'd0);

        // Length 0 behaves as a window of one: threshold is twice the
        // previous sample, up to the 17-bit maximum.
        write_window_length('0);
        offer_sample(16'd7);
        offer_sample(16'd14);
        offer_sample(16'd13);
        offer_sample(16'd65535);
        offer_sample(16'd65535);
        offer_sample(16'd0);
        offer_sample(16'd0);

        // Random bursts, one window setting and one traffic shape each.
        run_burst(9'd3, 30, 70, 0, 1'b0);
        run_burst(9'd2, 30, 0, 70, 1'b0);
        run_burst(9'd1, 30, 21, 21, 1'b0);
        // receiver holds off while the sender keeps pushing
        run_burst(9'($urandom_range(4, 16)), 45, 0, 0, 1'b1);
        // all-ones length clamps to the largest window; fill it and run past
        run_burst(9'd511, 280, 21, 21, 1'b0);
        run_burst(9'($urandom_range(4, 12)), 30, 0, 70, 1'b0);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d sample requests across %0d window length settings,", sent_count,
                 settings_used);
        $display("checked %0d results, %0d of them alarms.", results_checked, alarms_seen);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/smta_pkg.sv
design/smta_cell.sv
design/smta_median_tree.sv
design/smta_delay_line.sv
design/sliding_median_threshold_alarm_core.sv
verif/smta_result_checker.sv
verif/tb_sliding_median_threshold_alarm_core.sv
